### design/wsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types and constants for the masked frame encoder.
// ----------------------------------------------------------------------------
package wsm_pkg;

  localparam int MaxFrameBytes = 2048;
  localparam int RemW          = $clog2(MaxFrameBytes + 1);
  localparam int SumW          = 18;
  localparam int BurstMax      = 8;
  localparam int BurstIdxW     = $clog2(BurstMax);

  localparam logic [7:0]  FinBit        = 8'h80;
  localparam logic [7:0]  MaskBit       = 8'h80;
  localparam logic [15:0] MaxShortLen   = 16'd125;
  localparam logic [6:0]  Len16Code     = 7'd126;
  localparam logic [31:0] MaskKeyReset  = 32'h13377742;
  localparam int          ShortHdrBytes = 6;
  localparam int          LongHdrBytes  = 8;

  localparam int AddrW = 3;
  localparam logic RegLinkUp  = 1'b0;
  localparam logic RegMaskKey = 1'b1;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_DATA  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LINK_DOWN = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_STRAY     = 2'd3
  } status_e;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  opcode;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic        link_up;
    logic [31:0] mask_key;
  } cfg_t;

  typedef struct packed {
    logic [BurstMax-1:0][7:0] bytes;
    logic [BurstIdxW-1:0]     cnt_m1;
    logic                     last;
    status_e                  status;
  } burst_t;

endpackage

### design/wsm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_in_if / wsm_out_if
// Valid/ready channels for request items and frame byte items.
// ----------------------------------------------------------------------------
interface wsm_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  opcode;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, req_type, opcode, payload_length, data_byte, input ready);
  modport sink   (input valid, req_type, opcode, payload_length, data_byte, output ready);
endinterface

interface wsm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_last;
  logic [1:0] status;

  modport source (output valid, out_byte, frame_last, status, input ready);
  modport sink   (input valid, out_byte, frame_last, status, output ready);
endinterface

### design/wsm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_cfg_regs
// APB register file: link_up at 0x0, mask_key at 0x4.
// ----------------------------------------------------------------------------
module wsm_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [wsm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output wsm_pkg::cfg_t            cfg_o
);

  logic        link_up_q, link_up_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    link_up_d  = link_up_q;
    mask_key_d = mask_key_q;
    if (wr_en) begin
      case (paddr[2])
        wsm_pkg::RegLinkUp:  link_up_d  = pwdata[0];
        wsm_pkg::RegMaskKey: mask_key_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_up_q  <= 1'b0;
      mask_key_q <= wsm_pkg::MaskKeyReset;
    end else begin
      link_up_q  <= link_up_d;
      mask_key_q <= mask_key_d;
    end
  end

  always_comb begin
    case (paddr[2])
      wsm_pkg::RegLinkUp:  prdata = {31'd0, link_up_q};
      wsm_pkg::RegMaskKey: prdata = mask_key_q;
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o.link_up  = link_up_q;
  assign cfg_o.mask_key = mask_key_q;

endmodule

### design/wsm_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_encoder
// Frame state and per-item byte burst: header plus key for a start, one
// masked byte for payload, one status byte for rejects.
// ----------------------------------------------------------------------------
module wsm_encoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  wsm_pkg::item_t  item_i,
  input  wsm_pkg::cfg_t   cfg_i,
  output wsm_pkg::burst_t burst_o
);

  logic [wsm_pkg::RemW-1:0] rem_q, rem_d;
  logic [1:0]               pos_q, pos_d;
  logic                     open_q, open_d;

  logic                     long_len;
  logic [wsm_pkg::SumW-1:0] frame_sum;
  logic                     too_large;
  logic [3:0][7:0]          key;
  logic [1:0]               key_sel;
  logic                     data_last;

  assign key[0] = cfg_i.mask_key[31:24];
  assign key[1] = cfg_i.mask_key[23:16];
  assign key[2] = cfg_i.mask_key[15:8];
  assign key[3] = cfg_i.mask_key[7:0];

  assign long_len  = item_i.payload_length > wsm_pkg::MaxShortLen;
  assign frame_sum = wsm_pkg::SumW'(item_i.payload_length)
                   + (long_len ? wsm_pkg::SumW'(wsm_pkg::LongHdrBytes)
                               : wsm_pkg::SumW'(wsm_pkg::ShortHdrBytes));
  assign too_large = frame_sum > wsm_pkg::SumW'(wsm_pkg::MaxFrameBytes);
  assign key_sel   = pos_q;
  assign data_last = rem_q == wsm_pkg::RemW'(1);

  always_comb begin
    rem_d          = rem_q;
    pos_d          = pos_q;
    open_d         = open_q;
    burst_o.bytes  = '0;
    burst_o.cnt_m1 = '0;
    burst_o.last   = 1'b1;
    burst_o.status = wsm_pkg::ST_OK;
    case (wsm_pkg::req_e'(item_i.req_type))
      wsm_pkg::REQ_START: begin
        if (!cfg_i.link_up) begin
          burst_o.status = wsm_pkg::ST_LINK_DOWN;
        end else if (too_large) begin
          burst_o.status = wsm_pkg::ST_TOO_LARGE;
        end else if (long_len) begin
          burst_o.bytes[0] = wsm_pkg::FinBit | {4'd0, item_i.opcode};
          burst_o.bytes[1] = wsm_pkg::MaskBit | {1'b0, wsm_pkg::Len16Code};
          burst_o.bytes[2] = item_i.payload_length[15:8];
          burst_o.bytes[3] = item_i.payload_length[7:0];
          burst_o.bytes[4] = key[0];
          burst_o.bytes[5] = key[1];
          burst_o.bytes[6] = key[2];
          burst_o.bytes[7] = key[3];
          burst_o.cnt_m1   = wsm_pkg::BurstIdxW'(wsm_pkg::LongHdrBytes - 1);
          burst_o.last     = 1'b0;
        end else begin
          burst_o.bytes[0] = wsm_pkg::FinBit | {4'd0, item_i.opcode};
          burst_o.bytes[1] = wsm_pkg::MaskBit | {1'b0, item_i.payload_length[6:0]};
          burst_o.bytes[2] = key[0];
          burst_o.bytes[3] = key[1];
          burst_o.bytes[4] = key[2];
          burst_o.bytes[5] = key[3];
          burst_o.cnt_m1   = wsm_pkg::BurstIdxW'(wsm_pkg::ShortHdrBytes - 1);
          burst_o.last     = item_i.payload_length == 16'd0;
        end
        open_d = cfg_i.link_up && !too_large && (item_i.payload_length != 16'd0);
        rem_d  = open_d ? wsm_pkg::RemW'(item_i.payload_length) : '0;
        pos_d  = 2'd0;
      end
      wsm_pkg::REQ_DATA: begin
        if (!open_q) begin
          burst_o.status = wsm_pkg::ST_STRAY;
        end else begin
          burst_o.bytes[0] = item_i.data_byte ^ key[key_sel];
          burst_o.last     = data_last;
          rem_d            = rem_q - wsm_pkg::RemW'(1);
          pos_d            = data_last ? 2'd0 : pos_q + 2'd1;
          open_d           = !data_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      pos_q  <= '0;
      open_q <= 1'b0;
    end else if (accept_i) begin
      rem_q  <= rem_d;
      pos_q  <= pos_d;
      open_q <= open_d;
    end
  end

  a_open_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> rem_q != '0)
    else $error("open frame with no bytes remaining");

  a_closed_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (pos_q == 2'd0 && rem_q == '0))
    else $error("closed frame left mask position or count");

endmodule

### design/wsm_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_serializer
// Result register: holds one burst and sends its bytes one per cycle while out_o.ready is high.
// ----------------------------------------------------------------------------
module wsm_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  wsm_pkg::burst_t burst_i,
  output logic            ready_o,
  wsm_out_if.source       out_o
);

  wsm_pkg::burst_t               burst_q;
  logic                          valid_q, valid_d;
  logic [wsm_pkg::BurstIdxW-1:0] idx_q, idx_d;
  logic                          at_end;
  logic                          take;

  assign at_end  = idx_q == burst_q.cnt_m1;
  assign take    = valid_q && out_o.ready;
  assign ready_o = !valid_q || (take && at_end);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take) begin
      if (at_end) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = burst_q.bytes[idx_q];
  assign out_o.frame_last = burst_q.last && at_end;
  assign out_o.status     = burst_q.status;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q <= burst_q.cnt_m1)
    else $error("byte index past end of burst");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("burst loaded while previous one pending");

endmodule

### design/websocket_client_frame_masker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_client_frame_masker
// Masked client WebSocket frame encoder producing a byte stream.
//
// in_i carries request items: a start item (req_type 0) with opcode and
// payload_length, or a payload item (req_type 1) with data_byte. out_o
// carries frame bytes, each with its frame_last and status. Registers on
// the APB port: link_up at 0x0, mask_key at 0x4 (pready always high).
// A start item becomes a burst of 6 or 8 header and key bytes, a reject or
// payload item one byte. The first byte appears in the cycle after accept.
// A burst holds the output register until its last byte leaves, so payload
// items stream at one per cycle while out_o.ready is high; a start holds
// in_i for its whole burst. The next item is taken as the last byte leaves.
// When the receiver stalls, the held byte stays on out_o and in_i.ready
// drops once that burst cannot drain. Reset closes any frame, empties the
// output register, clears link_up and loads the default mask key.
// ----------------------------------------------------------------------------
module websocket_client_frame_masker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  wsm_in_if.sink                    in_i,
  wsm_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wsm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  wsm_pkg::cfg_t   cfg;
  wsm_pkg::item_t  item;
  wsm_pkg::burst_t burst;
  logic            ser_ready;
  logic            accept;

  assign item.req_type       = in_i.req_type;
  assign item.opcode         = in_i.opcode;
  assign item.payload_length = in_i.payload_length;
  assign item.data_byte      = in_i.data_byte;
  assign in_i.ready          = ser_ready;
  assign accept              = in_i.valid && ser_ready;

  wsm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wsm_encoder u_enc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .burst_o  (burst)
  );

  wsm_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .burst_i (burst),
    .ready_o (ser_ready),
    .out_o   (out_o)
  );

endmodule

### verif/websocket_client_frame_masker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_client_frame_masker_tb
// Self-checking bench for the masked client frame encoder.
//
// Request items go in on in_i and frame bytes come back on out_o. A scoreboard
// model of the encoder predicts every byte. Covered: header forms (short and
// 16-bit length, empty payload), mask rotation, rejects (link down, oversize,
// stray payload), abandoned frames, register changes between bytes of an open
// frame, APB readback, and random traffic with stalls on both sides.
// ----------------------------------------------------------------------------
module websocket_client_frame_masker_tb;

  localparam logic [wsm_pkg::AddrW-1:0] AddrLinkUp  = {wsm_pkg::RegLinkUp, 2'b00};
  localparam logic [wsm_pkg::AddrW-1:0] AddrMaskKey = {wsm_pkg::RegMaskKey, 2'b00};

  typedef struct {
    logic [7:0]       data;
    logic             last;
    wsm_pkg::status_e st;
  } frame_byte_t;

  logic clk;
  logic rst_n;

  wsm_in_if  in_bus ();
  wsm_out_if out_bus ();

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [wsm_pkg::AddrW-1:0] paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  websocket_client_frame_masker dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // encoder model state
  logic        mdl_link;
  logic [31:0] mdl_key;
  logic [15:0] mdl_left;
  logic [1:0]  mdl_pos;
  logic        mdl_open;

  frame_byte_t frame_byte_q[$];
  frame_byte_t got_exp;
  int          err_cnt;
  int          items_sent;
  bit          idle_en;
  int          out_stall;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  task automatic report_err(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    err_cnt++;
  endtask

  function automatic logic [7:0] key_byte(int idx);
    return mdl_key[8*(3-idx) +: 8];
  endfunction

  function automatic void push_byte(logic [7:0] data, logic last, wsm_pkg::status_e st);
    frame_byte_t b;
    b.data = data;
    b.last = last;
    b.st   = st;
    frame_byte_q.push_back(b);
  endfunction

  function automatic void encode_item(wsm_pkg::req_e req, logic [3:0] op,
                                      logic [15:0] len, logic [7:0] data);
    int hdr;
    if (req == wsm_pkg::REQ_START) begin
      mdl_open = 1'b0;
      mdl_left = '0;
      mdl_pos  = '0;
      if (!mdl_link) begin
        push_byte(8'h00, 1'b1, wsm_pkg::ST_LINK_DOWN);
        return;
      end
      hdr = (len > wsm_pkg::MaxShortLen) ? wsm_pkg::LongHdrBytes
                                         : wsm_pkg::ShortHdrBytes;
      if (hdr + int'(len) > wsm_pkg::MaxFrameBytes) begin
        push_byte(8'h00, 1'b1, wsm_pkg::ST_TOO_LARGE);
        return;
      end
      push_byte(wsm_pkg::FinBit | {4'h0, op}, 1'b0, wsm_pkg::ST_OK);
      if (len <= wsm_pkg::MaxShortLen) begin
        push_byte(wsm_pkg::MaskBit | {1'b0, len[6:0]}, 1'b0, wsm_pkg::ST_OK);
      end else begin
        push_byte(wsm_pkg::MaskBit | {1'b0, wsm_pkg::Len16Code}, 1'b0, wsm_pkg::ST_OK);
        push_byte(len[15:8], 1'b0, wsm_pkg::ST_OK);
        push_byte(len[7:0], 1'b0, wsm_pkg::ST_OK);
      end
      for (int i = 0; i < 4; i++) begin
        push_byte(key_byte(i), (i == 3) && (len == 0), wsm_pkg::ST_OK);
      end
      if (len != 0) begin
        mdl_open = 1'b1;
        mdl_left = len;
      end
    end else begin
      if (!mdl_open) begin
        push_byte(8'h00, 1'b1, wsm_pkg::ST_STRAY);
        return;
      end
      mdl_left = mdl_left - 16'd1;
      push_byte(data ^ key_byte(mdl_pos), mdl_left == 0, wsm_pkg::ST_OK);
      mdl_pos = mdl_pos + 2'd1;
      if (mdl_left == 0) begin
        mdl_open = 1'b0;
        mdl_pos  = '0;
      end
    end
  endfunction

  task automatic send_item(wsm_pkg::req_e req, logic [3:0] op, logic [15:0] len,
                           logic [7:0] data);
    int gap;
    if (idle_en && ($urandom_range(0, 4) == 0)) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid          <= 1'b1;
    in_bus.req_type       <= req;
    in_bus.opcode         <= op;
    in_bus.payload_length <= len;
    in_bus.data_byte      <= data;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    encode_item(req, op, len, data);
    items_sent++;
  endtask

  task automatic send_payload(int n);
    for (int i = 0; i < n; i++) begin
      send_item(wsm_pkg::REQ_DATA, 4'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (frame_byte_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_read(logic [wsm_pkg::AddrW-1:0] addr);
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (addr == AddrLinkUp) ? {31'h0, mdl_link} : mdl_key;
    if (prdata !== want) begin
      report_err($sformatf("readback addr %0h: got %08h want %08h", addr, prdata, want));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(logic [wsm_pkg::AddrW-1:0] addr, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == AddrLinkUp) mdl_link = value[0];
    else mdl_key = value;
    cfg_read(addr);
  endtask

  task automatic set_link(logic up);
    cfg_write(AddrLinkUp, {31'($urandom), up});
  endtask

  // ready on out_o: random stall bursts unless idling is off
  always @(negedge clk) begin
    if (!idle_en) begin
      out_bus.ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_bus.ready <= 1'b0;
      out_stall--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(1, 10) - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (frame_byte_q.size() == 0) begin
        report_err($sformatf("unexpected byte %02h last %0b status %0d",
                             out_bus.out_byte, out_bus.frame_last, out_bus.status));
      end else begin
        got_exp = frame_byte_q.pop_front();
        if (out_bus.out_byte !== got_exp.data) begin
          report_err($sformatf("out_byte got %02h want %02h", out_bus.out_byte, got_exp.data));
        end
        if (out_bus.frame_last !== got_exp.last) begin
          report_err($sformatf("frame_last got %0b want %0b",
                               out_bus.frame_last, got_exp.last));
        end
        if (out_bus.status !== got_exp.st) begin
          report_err($sformatf("status got %0d want %0d", out_bus.status, got_exp.st));
        end
      end
    end
  end

  task automatic test_reset_state();
    cfg_read(AddrLinkUp);
    cfg_read(AddrMaskKey);
    send_item(wsm_pkg::REQ_START, 4'h1, 16'd4, 8'h00);
    send_item(wsm_pkg::REQ_DATA, 4'h0, 16'd0, 8'hA5);
    wait_idle();
    set_link(1'b1);
  endtask

  task automatic test_header_forms();
    send_item(wsm_pkg::REQ_START, 4'h0, 16'd0, 8'h00);
    send_item(wsm_pkg::REQ_START, 4'hF, 16'd1, 8'h00);
    send_item(wsm_pkg::REQ_DATA, 4'h0, 16'd0, 8'hFF);
    send_item(wsm_pkg::REQ_START, 4'h1, 16'd125, 8'h00);
    send_item(wsm_pkg::REQ_DATA, 4'h0, 16'd0, 8'h00);
    send_item(wsm_pkg::REQ_DATA, 4'h0, 16'd0, 8'hFF);
    send_item(wsm_pkg::REQ_START, 4'h2, 16'd126, 8'h00);
    send_item(wsm_pkg::REQ_DATA, 4'h0, 16'd0, 8'h00);
    send_item(wsm_pkg::REQ_DATA, 4'h0, 16'd0, 8'hFF);
    send_item(wsm_pkg::REQ_DATA, 4'h0, 16'd0, 8'h5A);
    send_item(wsm_pkg::REQ_DATA, 4'h0, 16'd0, 8'hA5);
    send_item(wsm_pkg::REQ_DATA, 4'h0, 16'd0, 8'h3C);
    send_item(wsm_pkg::REQ_START, 4'h8, 16'd2040, 8'h00);
    send_item(wsm_pkg::REQ_START, 4'h9, 16'd2041, 8'h00);
    send_item(wsm_pkg::REQ_START, 4'hA, 16'hFFFF, 8'h00);
    send_item(wsm_pkg::REQ_START, 4'h9, 16'd4, 8'h00);
    send_payload(4);
    send_item(wsm_pkg::REQ_DATA, 4'hF, 16'hFFFF, 8'h3C);
    wait_idle();
  endtask

  task automatic test_midframe_config();
    send_item(wsm_pkg::REQ_START, 4'h1, 16'd6, 8'h00);
    send_payload(2);
    wait_idle();
    set_link(1'b0);
    cfg_write(AddrMaskKey, 32'hA5C30F96);
    send_payload(4);
    wait_idle();
    send_item(wsm_pkg::REQ_START, 4'h2, 16'd3, 8'h00);
    wait_idle();
    set_link(1'b1);
  endtask

  task automatic random_frames(int n_items);
    int stop_at;
    int roll;
    int len;
    int n_bytes;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_payload(1);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) len = $urandom_range(0, 24);
        else if (roll < 75) len = $urandom_range(120, 131);
        else if (roll < 85) len = $urandom_range(126, 300);
        else if (roll < 93) len = $urandom_range(2041, 65535);
        else len = $urandom_range(2030, 2048);
        send_item(wsm_pkg::REQ_START, 4'($urandom), 16'(len), 8'($urandom));
        n_bytes = (len <= 40) ? len : $urandom_range(0, 12);
        if ($urandom_range(0, 9) == 0) n_bytes = $urandom_range(0, n_bytes);
        send_payload(n_bytes);
      end
    end
    wait_idle();
  endtask

  task automatic test_random_phases();
    cfg_write(AddrMaskKey, 32'h00000000);
    random_frames(40);
    cfg_write(AddrMaskKey, 32'hFFFFFFFF);
    random_frames(40);
    cfg_write(AddrMaskKey, $urandom);
    random_frames(35);
    set_link(1'b0);
    random_frames(20);
    set_link(1'b1);
    cfg_write(AddrMaskKey, $urandom);
    random_frames(40);
  endtask

  task automatic test_streaming();
    idle_en = 1'b0;
    cfg_write(AddrMaskKey, $urandom);
    random_frames(40);
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.req_type       = wsm_pkg::REQ_START;
    in_bus.opcode         = '0;
    in_bus.payload_length = '0;
    in_bus.data_byte      = '0;
    out_bus.ready         = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    mdl_link              = 1'b0;
    mdl_key               = wsm_pkg::MaskKeyReset;
    mdl_left              = '0;
    mdl_pos               = '0;
    mdl_open              = 1'b0;
    err_cnt               = 0;
    items_sent            = 0;
    idle_en               = 1'b1;
    out_stall             = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_header_forms();
    test_midframe_config();
    test_random_phases();
    test_streaming();

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
